### sv/bjs_pkg.sv
// ----------------------------------------------------------------------------
// bjs_pkg
// Shared types and constants of the binary jaccard similarity unit.
// ----------------------------------------------------------------------------
package bjs_pkg;

  localparam int MAX_WORDS_DEFAULT = 1024;

  localparam int WORD_W  = 64;
  localparam int CNT_W   = 17;
  localparam int POP_W   = 7;
  localparam int FRAC_W  = 16;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(65536);
  localparam logic [CNT_W-1:0] ONE_FIXED   = CNT_W'(65536);

  // one quotient bit per divider step
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CNT_W - 1);

  typedef enum logic [1:0] {
    S_ACCUM,
    S_DIVIDE,
    S_DONE
  } bjs_state_t;

  typedef struct packed {
    logic accum;     // add a word that is not the last one
    logic finish;    // add the last word, hand totals to the divider
    logic div_step;  // one restoring division step
    logic out_load;  // move the finished result to the output register
  } bjs_cmd_t;

  typedef struct packed {
    logic div_last;  // divider is on its final step
  } bjs_status_t;

endpackage

### sv/bjs_ctrl.sv
// ----------------------------------------------------------------------------
// bjs_ctrl
// Controller: sequences accumulation, division and the output handshake.
// ----------------------------------------------------------------------------
module bjs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                last_word,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output bjs_pkg::bjs_cmd_t    cmd,
  input  bjs_pkg::bjs_status_t status
);

  bjs_pkg::bjs_state_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bjs_pkg::S_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bjs_pkg::S_ACCUM: begin
        if (in_valid && last_word) state_next = bjs_pkg::S_DIVIDE;
      end
      bjs_pkg::S_DIVIDE: begin
        if (status.div_last) state_next = bjs_pkg::S_DONE;
      end
      bjs_pkg::S_DONE: begin
        if (out_free) state_next = bjs_pkg::S_ACCUM;
      end
      default: state_next = bjs_pkg::S_ACCUM;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      bjs_pkg::S_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accum  = in_valid && !last_word;
        cmd.finish = in_valid && last_word;
      end
      bjs_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      bjs_pkg::S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### sv/bjs_datapath.sv
// ----------------------------------------------------------------------------
// bjs_datapath
// Datapath: popcount accumulators, restoring divider and result register.
// ----------------------------------------------------------------------------
module bjs_datapath #(
  parameter int MAX_WORDS = bjs_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bjs_pkg::WORD_W-1:0] word_a,
  input  logic [bjs_pkg::WORD_W-1:0] word_b,
  input  bjs_pkg::bjs_cmd_t           cmd,
  output bjs_pkg::bjs_status_t        status,
  output logic [bjs_pkg::CNT_W-1:0]  similarity,
  output logic [bjs_pkg::CNT_W-1:0]  common_bits,
  output logic [bjs_pkg::CNT_W-1:0]  union_bits,
  output logic                       too_long
);

  localparam int CW  = bjs_pkg::CNT_W;
  localparam int WCW = $clog2(MAX_WORDS + 1);

  // accumulators
  logic [CW-1:0]  inter_cnt, union_cnt;
  logic           ovf;
  logic [WCW-1:0] word_cnt;

  logic [bjs_pkg::POP_W-1:0] pop_and, pop_or;
  logic          in_range;
  logic [CW:0]   inter_sum, union_sum;
  logic          inter_sat, union_sat;
  logic [CW-1:0] inter_new, union_new;
  logic          ovf_new;

  // divider
  logic [CW-1:0]             div_i, div_u, res_ovf_dummy;
  logic                      res_ovf;
  logic [CW-1:0]             rem, dvd, quo;
  logic [bjs_pkg::STEP_W-1:0] step_cnt;
  logic [CW:0]               rem_sh;
  logic [CW+1:0]             diff;
  logic                      ge;

  assign pop_and = bjs_pkg::POP_W'($countones(word_a & word_b));
  assign pop_or  = bjs_pkg::POP_W'($countones(word_a | word_b));

  assign in_range  = word_cnt < WCW'(MAX_WORDS);
  assign inter_sum = {1'b0, inter_cnt} + (CW + 1)'(pop_and);
  assign union_sum = {1'b0, union_cnt} + (CW + 1)'(pop_or);
  assign inter_sat = inter_sum > {1'b0, bjs_pkg::COUNT_LIMIT};
  assign union_sat = union_sum > {1'b0, bjs_pkg::COUNT_LIMIT};

  // words past the limit add nothing and only mark the vector
  always_comb begin
    if (in_range) begin
      inter_new = inter_sat ? bjs_pkg::COUNT_LIMIT : inter_sum[CW-1:0];
      union_new = union_sat ? bjs_pkg::COUNT_LIMIT : union_sum[CW-1:0];
      ovf_new   = ovf || inter_sat || union_sat;
    end else begin
      inter_new = inter_cnt;
      union_new = union_cnt;
      ovf_new   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inter_cnt <= '0;
      union_cnt <= '0;
      ovf       <= 1'b0;
      word_cnt  <= '0;
    end else if (cmd.finish) begin
      inter_cnt <= '0;
      union_cnt <= '0;
      ovf       <= 1'b0;
      word_cnt  <= '0;
    end else if (cmd.accum) begin
      inter_cnt <= inter_new;
      union_cnt <= union_new;
      ovf       <= ovf_new;
      if (in_range) word_cnt <= word_cnt + WCW'(1);
    end
  end

  // restoring division of (i << 16) by u; i <= u so the quotient fits 17 bits
  // and the first 16 steps reduce to starting the remainder at i >> 1
  assign rem_sh = {rem, dvd[CW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_u};
  assign ge     = !diff[CW+1];

  assign status.div_last = step_cnt == bjs_pkg::STEP_LAST;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      div_i    <= inter_new;
      div_u    <= union_new;
      res_ovf  <= ovf_new;
      rem      <= {1'b0, inter_new[CW-1:1]};
      dvd      <= {inter_new[0], {(CW-1){1'b0}}};
      quo      <= '0;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      rem      <= ge ? diff[CW-1:0] : rem_sh[CW-1:0];
      dvd      <= {dvd[CW-2:0], 1'b0};
      quo      <= {quo[CW-2:0], ge};
      step_cnt <= step_cnt + bjs_pkg::STEP_W'(1);
    end
  end

  assign res_ovf_dummy = '0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      similarity  <= (div_u == res_ovf_dummy) ? bjs_pkg::ONE_FIXED : quo;
      common_bits <= div_i;
      union_bits  <= div_u;
      too_long    <= res_ovf;
    end
  end

endmodule

### sv/binary_jaccard_similarity_unit.sv
// ----------------------------------------------------------------------------
// binary_jaccard_similarity_unit
// Jaccard similarity of two bit vectors streamed as 64-bit word pairs.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word pair of the two vectors per
// word, last_word marks the final pair. Non-final words are taken at one per
// cycle, with no stall while an earlier result waits at the output.
// After the last word the unit runs a restoring divider, one quotient bit a
// cycle, and then loads the output register; in_ready stays low from the
// first divider step until the result is loaded into the output register.
// Output channel (out_valid/out_ready): similarity (16 fraction bits, 1.0 for
// an empty union), both counts and too_long. The result register holds until
// taken; if it is still full when the next result is ready, the unit waits
// with in_ready low. Words past MAX_WORDS add nothing and set too_long.
// Reset (rst, synchronous) clears counts, state and out_valid.
// ----------------------------------------------------------------------------
module binary_jaccard_similarity_unit #(
  parameter int MAX_WORDS = bjs_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bjs_pkg::WORD_W-1:0] word_a,
  input  logic [bjs_pkg::WORD_W-1:0] word_b,
  input  logic                       last_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bjs_pkg::CNT_W-1:0]  similarity,
  output logic [bjs_pkg::CNT_W-1:0]  common_bits,
  output logic [bjs_pkg::CNT_W-1:0]  union_bits,
  output logic                       too_long
);

  bjs_pkg::bjs_cmd_t    cmd;
  bjs_pkg::bjs_status_t status;

  bjs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_word (last_word),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  bjs_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .word_a      (word_a),
    .word_b      (word_b),
    .cmd         (cmd),
    .status      (status),
    .similarity  (similarity),
    .common_bits (common_bits),
    .union_bits  (union_bits),
    .too_long    (too_long)
  );

  // ratio never exceeds 1.0
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> similarity <= bjs_pkg::ONE_FIXED)
    else $error("similarity above 1.0");

  // the and-count can never pass the or-count
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> common_bits <= union_bits)
    else $error("common_bits above union_bits");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && union_bits == '0 |-> similarity == bjs_pkg::ONE_FIXED)
    else $error("empty union not reported as 1.0");

  // divider is busy right after the last word is taken
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_word |=> !in_ready)
    else $error("word taken while dividing");

endmodule
